[sv/interpolating_sample_voice_mixer_defines.svh]
// Assertion helpers shared by the voice mixer modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef INTERPOLATING_SAMPLE_VOICE_MIXER_DEFINES_SVH
`define INTERPOLATING_SAMPLE_VOICE_MIXER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ISVM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define ISVM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/isvm_pkg.sv]
package isvm_pkg;

  // Table and channel sizing
  localparam int SAMPLE_DEPTH = 4096;
  localparam int CHANNELS     = 2;
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int IDX_W        = ADDR_W + 1;
  localparam int FRAC_W       = 16;
  localparam int PHASE_W      = IDX_W + FRAC_W;

  // Field widths
  localparam int SAMPLE_W     = 16;
  localparam int STEP_W       = 20;
  localparam int START_W      = 28;
  localparam int VOL_W        = 16;
  localparam int COUNT_W      = 13;
  localparam int CFG_W        = 28;
  localparam int CFG_IDX_W    = 3;

  // Command queue depth
  localparam int QUEUE_DEPTH  = 2;

  // Register reset values and limits
  localparam logic [STEP_W-1:0] STEP_RESET = 20'h10000;
  localparam logic [VOL_W-1:0]  VOL_RESET  = 16'd16384;
  localparam logic [VOL_W-1:0]  VOL_MAX    = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP   = 3'd0,
    REG_START_PHASE  = 3'd1,
    REG_VOLUME       = 3'd2,
    REG_LOOP_ENABLE  = 3'd3,
    REG_SAMPLE_COUNT = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_RENDER,
    OP_RESTART
  } op_t;

  typedef struct packed {
    logic [1:0]                 func;
    logic [11:0]                sample_addr;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic signed [SAMPLE_W-1:0] existing_left;
    logic signed [SAMPLE_W-1:0] existing_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed_left;
    logic signed [SAMPLE_W-1:0] mixed_right;
    logic                       voice_done;
  } out_item_t;

  typedef struct packed {
    logic [STEP_W-1:0]  phase_step;
    logic [START_W-1:0] start_phase;
    logic [VOL_W-1:0]   volume;
    logic               loop_enable;
    logic [COUNT_W-1:0] sample_count;
  } cfg_t;

  typedef struct packed {
    op_t                        op;
    logic [11:0]                addr;
    logic signed [SAMPLE_W-1:0] value;
    logic signed [SAMPLE_W-1:0] ex_left;
    logic signed [SAMPLE_W-1:0] ex_right;
  } cmd_t;

endpackage

[sv/isvm_ram.sv]
module isvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         ra_data,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] ra_data_r;
  logic [WIDTH-1:0] rb_data_r;

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    ra_data_r <= mem_r[ra_addr];
    rb_data_r <= mem_r[rb_addr];
  end

  assign ra_data = ra_data_r;
  assign rb_data = rb_data_r;

endmodule

[sv/isvm_front.sv]
module isvm_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  isvm_pkg::in_item_t                  in_item,
  output logic                                in_stall,
  input  logic                                cfg_we,
  input  logic [isvm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [isvm_pkg::CFG_W-1:0]          cfg_wdata,
  output isvm_pkg::cfg_t                      cfg,
  input  logic                                q_full,
  output logic                                q_push,
  output isvm_pkg::cmd_t                      q_cmd
);

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_RENDER  = 2'd1,
    FUNC_RESTART = 2'd2
  } func_t;

  isvm_pkg::cfg_t cfg_r;
  isvm_pkg::cfg_t cfg_nxt;
  logic           accept;
  logic           keep;

  // Stall while the queue has no room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Classify the beat; drop unused codes and out-of-range loads
  always_comb begin
    q_cmd.addr     = in_item.sample_addr;
    q_cmd.value    = in_item.sample_value;
    q_cmd.ex_left  = in_item.existing_left;
    q_cmd.ex_right = in_item.existing_right;
    q_cmd.op       = isvm_pkg::OP_RENDER;
    keep           = 1'b0;
    case (in_item.func)
      FUNC_LOAD: begin
        q_cmd.op = isvm_pkg::OP_LOAD;
        keep     = int'(in_item.sample_addr) < isvm_pkg::SAMPLE_DEPTH;
      end
      FUNC_RENDER: begin
        q_cmd.op = isvm_pkg::OP_RENDER;
        keep     = 1'b1;
      end
      FUNC_RESTART: begin
        q_cmd.op = isvm_pkg::OP_RESTART;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push = accept && keep;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        isvm_pkg::REG_PHASE_STEP:
          cfg_nxt.phase_step = cfg_wdata[isvm_pkg::STEP_W-1:0];
        isvm_pkg::REG_START_PHASE:
          cfg_nxt.start_phase = cfg_wdata[isvm_pkg::START_W-1:0];
        isvm_pkg::REG_VOLUME:
          cfg_nxt.volume = cfg_wdata[isvm_pkg::VOL_W-1:0];
        isvm_pkg::REG_LOOP_ENABLE:
          cfg_nxt.loop_enable = cfg_wdata[0];
        isvm_pkg::REG_SAMPLE_COUNT:
          cfg_nxt.sample_count = cfg_wdata[isvm_pkg::COUNT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step   <= isvm_pkg::STEP_RESET;
      cfg_r.start_phase  <= '0;
      cfg_r.volume       <= isvm_pkg::VOL_RESET;
      cfg_r.loop_enable  <= 1'b0;
      cfg_r.sample_count <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/isvm_queue.sv]
`include "interpolating_sample_voice_mixer_defines.svh"

module isvm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  isvm_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output isvm_pkg::cmd_t head
);

  localparam int PTR_W = $clog2(isvm_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(isvm_pkg::QUEUE_DEPTH + 1);

  isvm_pkg::cmd_t   mem_r [isvm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign full  = cnt_r == CNT_W'(isvm_pkg::QUEUE_DEPTH);
  assign valid = cnt_r != '0;
  assign head  = mem_r[rd_ptr_r];

  // Advance pointers with wrap, track fill
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(isvm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(isvm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `ISVM_ASSERT_IMP(a_no_push_when_full, push && !pop, !full, "queue overflow")
  `ISVM_ASSERT_IMP(a_no_pop_when_empty, pop, valid, "queue underflow")
  `ISVM_ASSERT_NXT(a_push_fills, push && !pop, cnt_r != '0, "push lost")

endmodule

[sv/isvm_back.sv]
`include "interpolating_sample_voice_mixer_defines.svh"

module isvm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  isvm_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  isvm_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  output isvm_pkg::out_item_t out_item,
  input  logic                out_stall
);

  localparam int IDX_W       = isvm_pkg::IDX_W;
  localparam int FRAC_W      = isvm_pkg::FRAC_W;
  localparam int PHASE_W     = isvm_pkg::PHASE_W;
  localparam int ADDR_W      = isvm_pkg::ADDR_W;
  localparam int SAMPLE_W    = isvm_pkg::SAMPLE_W;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int PROD_W      = 34;
  localparam int INTERP_W    = 32;
  localparam int VOICE_W     = 48;
  localparam int VOICE_SHIFT = 30;
  localparam int TOT_W       = VOICE_W + 1;
  localparam int Q_W         = TOT_W - VOICE_SHIFT;
  localparam int CNT_W       = $clog2(IDX_W);

  localparam logic signed [TOT_W-1:0] TRUNC_BIAS = TOT_W'((64'sd1 <<< VOICE_SHIFT) - 64'sd1);
  localparam logic signed [Q_W-1:0]   SAT_MAX    = Q_W'(32767);
  localparam logic signed [Q_W-1:0]   SAT_MIN    = Q_W'(-32768);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_READ,
    S_INTERP,
    S_SCALE,
    S_MIX,
    S_OUT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [PHASE_W-1:0]         phase_r, phase_nxt;
  logic                       finished_r, finished_nxt;
  logic [IDX_W-1:0]           mod_rem_r, mod_rem_nxt;
  logic [IDX_W-1:0]           mod_div_r, mod_div_nxt;
  logic [CNT_W-1:0]           mod_cnt_r, mod_cnt_nxt;
  logic signed [SAMPLE_W-1:0] ex_l_r, ex_l_nxt;
  logic signed [SAMPLE_W-1:0] ex_r_r, ex_r_nxt;
  logic signed [INTERP_W-1:0] interp_r, interp_nxt;
  logic signed [VOICE_W-1:0]  voice_r, voice_nxt;
  logic signed [TOT_W-1:0]    tot_l_r, tot_l_nxt;
  logic signed [TOT_W-1:0]    tot_r_r, tot_r_nxt;
  logic                       out_valid_r, out_valid_nxt;
  isvm_pkg::out_item_t        out_item_r, out_item_nxt;

  logic [IDX_W-1:0]            count_sat;
  logic [isvm_pkg::VOL_W-1:0]  vol_sat;
  logic [IDX_W-1:0]            idx;
  logic [FRAC_W-1:0]           frac;
  logic [IDX_W-1:0]            idx_p1;
  logic [IDX_W-1:0]            idx1;
  logic [PHASE_W-1:0]          limit;
  logic [PHASE_W-1:0]          step_ext;
  logic [PHASE_W-1:0]          step_lim;
  logic [IDX_W-1:0]            rem_sh;
  logic [IDX_W-1:0]            rem_new;
  logic signed [SAMPLE_W-1:0]  s0;
  logic signed [SAMPLE_W-1:0]  s1;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [PROD_W-1:0]    interp_full;
  logic                        out_free;
  logic                        ram_we;
  logic [SAMPLE_W-1:0]         ra_data;
  logic [SAMPLE_W-1:0]         rb_data;

  // Truncate toward zero, then saturate to a 16-bit sample
  function automatic logic signed [SAMPLE_W-1:0] mix_sat(input logic signed [TOT_W-1:0] tot);
    logic signed [TOT_W-1:0] biased;
    logic signed [Q_W-1:0]   q;
    biased = tot[TOT_W-1] ? tot + TRUNC_BIAS : tot;
    q      = $signed(biased[TOT_W-1:VOICE_SHIFT]);
    if (q > SAT_MAX) begin
      return SAMPLE_W'(SAT_MAX);
    end else if (q < SAT_MIN) begin
      return SAMPLE_W'(SAT_MIN);
    end
    return q[SAMPLE_W-1:0];
  endfunction

  isvm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (isvm_pkg::SAMPLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ADDR_W'(q_cmd.addr)),
    .wdata   (q_cmd.value),
    .ra_addr (idx[ADDR_W-1:0]),
    .rb_addr (idx1[ADDR_W-1:0]),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  // Clamp count and volume, split the phase
  assign count_sat = (int'(cfg.sample_count) > isvm_pkg::SAMPLE_DEPTH)
                     ? IDX_W'(isvm_pkg::SAMPLE_DEPTH) : IDX_W'(cfg.sample_count);
  assign vol_sat   = (cfg.volume > isvm_pkg::VOL_MAX) ? isvm_pkg::VOL_MAX : cfg.volume;
  assign idx       = phase_r[PHASE_W-1:FRAC_W];
  assign frac      = phase_r[FRAC_W-1:0];
  assign idx_p1    = idx + IDX_W'(1);
  assign idx1      = (idx_p1 == count_sat) ? '0 : idx_p1;

  // Step limited to count * 65536 - 1
  assign limit     = {count_sat - IDX_W'(1), {FRAC_W{1'b1}}};
  assign step_ext  = PHASE_W'(cfg.phase_step);
  assign step_lim  = (step_ext > limit) ? limit : step_ext;

  // One restoring remainder step per cycle
  assign rem_sh    = {mod_rem_r[IDX_W-2:0], mod_div_r[IDX_W-1]};
  assign rem_new   = (rem_sh >= count_sat) ? rem_sh - count_sat : rem_sh;

  // Interpolate between neighbors
  assign s0          = $signed(ra_data);
  assign s1          = $signed(rb_data);
  assign diff        = DIFF_W'(s1) - DIFF_W'(s0);
  assign interp_full = (PROD_W'(s0) <<< FRAC_W)
                     + PROD_W'($signed({1'b0, frac})) * PROD_W'(diff);

  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    finished_nxt  = finished_r;
    mod_rem_nxt   = mod_rem_r;
    mod_div_nxt   = mod_div_r;
    mod_cnt_nxt   = mod_cnt_r;
    ex_l_nxt      = ex_l_r;
    ex_r_nxt      = ex_r_r;
    interp_nxt    = interp_r;
    voice_nxt     = voice_r;
    tot_l_nxt     = tot_l_r;
    tot_r_nxt     = tot_r_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            isvm_pkg::OP_LOAD: begin
              q_pop  = 1'b1;
              ram_we = 1'b1;
            end
            isvm_pkg::OP_RESTART: begin
              q_pop        = 1'b1;
              phase_nxt    = PHASE_W'(cfg.start_phase);
              finished_nxt = 1'b0;
            end
            isvm_pkg::OP_RENDER: begin
              if (out_free) begin
                q_pop                    = 1'b1;
                ex_l_nxt                 = q_cmd.ex_left;
                ex_r_nxt                 = q_cmd.ex_right;
                out_item_nxt.mixed_left  = q_cmd.ex_left;
                out_item_nxt.mixed_right = q_cmd.ex_right;
                out_item_nxt.voice_done  = 1'b0;
                if (count_sat == '0) begin
                  // Silent voice: pass the bus through
                  out_valid_nxt = 1'b1;
                end else if (finished_r) begin
                  out_item_nxt.voice_done = 1'b1;
                  out_valid_nxt           = 1'b1;
                end else if (idx >= count_sat) begin
                  if (cfg.loop_enable) begin
                    mod_rem_nxt = '0;
                    mod_div_nxt = idx;
                    mod_cnt_nxt = CNT_W'(IDX_W - 1);
                    state_nxt   = S_MOD;
                  end else begin
                    finished_nxt            = 1'b1;
                    out_item_nxt.voice_done = 1'b1;
                    out_valid_nxt           = 1'b1;
                  end
                end else begin
                  state_nxt = S_READ;
                end
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      S_MOD: begin
        // Wrap the index: remainder by count, one bit a cycle
        mod_rem_nxt = rem_new;
        mod_div_nxt = {mod_div_r[IDX_W-2:0], 1'b0};
        mod_cnt_nxt = mod_cnt_r - CNT_W'(1);
        if (mod_cnt_r == '0) begin
          phase_nxt = {rem_new, frac};
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // Table addresses are up; data lands next cycle
        state_nxt = S_INTERP;
      end
      S_INTERP: begin
        interp_nxt = $signed(interp_full[INTERP_W-1:0]);
        phase_nxt  = phase_r + step_lim;
        state_nxt  = S_SCALE;
      end
      S_SCALE: begin
        voice_nxt = VOICE_W'(interp_r) * VOICE_W'($signed({1'b0, vol_sat}));
        state_nxt = S_MIX;
      end
      S_MIX: begin
        tot_l_nxt = (TOT_W'(ex_l_r) <<< VOICE_SHIFT) + TOT_W'(voice_r);
        tot_r_nxt = (TOT_W'(ex_r_r) <<< VOICE_SHIFT) + TOT_W'(voice_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_item_nxt.mixed_left  = mix_sat(tot_l_r);
          out_item_nxt.mixed_right = (isvm_pkg::CHANNELS >= 2) ? mix_sat(tot_r_r) : ex_r_r;
          out_item_nxt.voice_done  = 1'b0;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mod_rem_r  <= mod_rem_nxt;
    mod_div_r  <= mod_div_nxt;
    mod_cnt_r  <= mod_cnt_nxt;
    ex_l_r     <= ex_l_nxt;
    ex_r_r     <= ex_r_nxt;
    interp_r   <= interp_nxt;
    voice_r    <= voice_nxt;
    tot_l_r    <= tot_l_nxt;
    tot_r_r    <= tot_r_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ISVM_ASSERT_IMP(a_pop_in_idle, q_pop, state_r == S_IDLE, "queue popped mid-item")
  `ISVM_ASSERT_IMP(a_mod_nonzero_count, state_r == S_MOD, count_sat != '0,
                   "wrap with empty table")
  `ISVM_ASSERT_IMP(a_read_in_range, state_r == S_READ, idx < count_sat,
                   "table read beyond count")

endmodule

[sv/interpolating_sample_voice_mixer.sv]
// Single sample-playback voice with linear interpolation.
// Input channel (in_valid / in_stall / in_item): each beat is a table load, a
// render request carrying the two mix-bus samples, or a restart. Unused codes
// are taken and dropped. A render beat gives exactly one output beat; loads and
// restarts give none.
// Output channel (out_valid / out_stall / out_item): mixed bus samples and the
// done flag of a non-looping voice. A held result waits in the output register
// while the back end goes on with queued loads and restarts; renders wait.
// Configuration (cfg_we / cfg_index / cfg_wdata) must be written while idle;
// the block itself does not enforce this. An interpolated render goes through
// the read, interpolate, scale, mix and output states, after the remainder step
// loop on a phase wrap; renders of a silent or finished voice skip them all.
// Throughput: while idle, the back end retires one load or restart per cycle;
// an interpolated render holds the back end through its single sequencer and
// table read port pair. A two-entry queue lets the front keep taking beats.
// Reset: registers return to their defaults, phase and done flag clear, the
// sample table keeps its contents. A stalled receiver fills the output
// register, then the queue, then raises in_stall.
module interpolating_sample_voice_mixer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  isvm_pkg::in_item_t             in_item,
  output logic                           in_stall,
  output logic                           out_valid,
  output isvm_pkg::out_item_t            out_item,
  input  logic                           out_stall,
  input  logic                           cfg_we,
  input  logic [isvm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [isvm_pkg::CFG_W-1:0]     cfg_wdata
);

  isvm_pkg::cfg_t cfg;
  isvm_pkg::cmd_t push_cmd;
  isvm_pkg::cmd_t head_cmd;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;

  isvm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  isvm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  isvm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule
